>>> rtl/core/apla_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apla_pkg
// shared types and constants of the address pool lease allocator
// ---------------------------------------------------------------------------
package apla_pkg;

  localparam int TableEntriesDefault = 16;

  localparam int AddrW     = 32;
  localparam int OffsetW   = 8;
  localparam int TicksW    = 8;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 32;

  // register indexes on the write port
  localparam logic [CfgIndexW-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_POOL_SIZE  = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_HOLD_TICKS = 2'd2;

  localparam logic [AddrW-1:0]   POOL_BASE_RESET  = 32'hC0A8_0100;
  localparam logic [OffsetW-1:0] POOL_SIZE_RESET  = 8'd255;
  localparam logic [TicksW-1:0]  HOLD_TICKS_RESET = 8'd10;

  // input item kinds
  localparam logic ACTION_REQUEST = 1'b0;
  localparam logic ACTION_TICK    = 1'b1;

  typedef enum logic [1:0] {
    REPLY_ACK        = 2'd0,
    REPLY_NAK_LEASED = 2'd1,
    REPLY_NAK_FULL   = 2'd2
  } reply_kind_t;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] wanted_address;
  } req_item_t;

  typedef struct packed {
    reply_kind_t      reply_kind;
    logic [AddrW-1:0] granted_address;
  } rsp_item_t;

endpackage

>>> rtl/core/address_pool_lease_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// address_pool_lease_allocator
// lease table over an address pool with lowest-free-offset allocation
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  apla_pkg::req_item_t
//   rsp      out        rsp_valid/rsp_stall  apla_pkg::rsp_item_t
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// a tick is applied as it is taken; a request steps through check, an optional scan and done
// the scan steps through the pool offsets: one pool offset per cycle goes
// through the single offset matcher, which compares it with all leases
// reset (rst, synchronous) empties the table and restores the registers
// a finished reply waits in the output register while the next transfer
// on req is taken; a new reply waits for that register to drain
// ---------------------------------------------------------------------------
module address_pool_lease_allocator #(
  parameter int TABLE_ENTRIES = apla_pkg::TableEntriesDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  apla_pkg::req_item_t                 req_item,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output apla_pkg::rsp_item_t                 rsp_item,
  input  logic                                cfg_we,
  input  logic [apla_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [apla_pkg::CfgDataW-1:0]       cfg_data
);
  import apla_pkg::*;

  localparam int SlotW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [AddrW-1:0]   pool_base;
  logic [OffsetW-1:0] pool_size;
  logic [TicksW-1:0]  hold_ticks;

  // lease table: valid bits in flops, offsets and counters written on grant, counters counted down on a tick
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [OffsetW-1:0]       entry_offset     [TABLE_ENTRIES];
  logic [TicksW-1:0]        entry_ticks_left [TABLE_ENTRIES];

  // request working registers
  logic [AddrW-1:0]   diff;       // wanted address less pool base
  logic [OffsetW-1:0] probe_off;  // offset under test in the scan
  logic [SlotW-1:0]   slot;       // table slot the grant goes into
  reply_kind_t        res_kind;
  logic [AddrW-1:0]   res_addr;

  // shared offset matcher
  logic [OffsetW-1:0]       probe;
  logic [TABLE_ENTRIES-1:0] hit;
  logic                     held;

  logic                     free_any;
  logic [SlotW-1:0]         free_slot;
  logic [TABLE_ENTRIES-1:0] tick_valid_next;
  logic                     diff_in_pool;
  logic                     scan_last;
  logic                     tick_take;
  logic                     req_take;
  logic                     rsp_load;

  assign req_stall = (state != S_IDLE);
  assign tick_take = (state == S_IDLE) && req_valid && (req_item.action == ACTION_TICK);
  assign req_take  = (state == S_IDLE) && req_valid && (req_item.action == ACTION_REQUEST);

  // reply moves into the output register once it is free or draining
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // the matcher sees the wanted offset in the check step, the scan offset after
  assign probe = (state == S_CHECK) ? diff[OffsetW-1:0] : probe_off;

  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      hit[k] = entry_valid[k] && (entry_offset[k] == probe);
    end
  end

  assign held = |hit;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (!entry_valid[k]) begin
        free_slot = SlotW'(k);
      end
    end
  end

  assign free_any = ~&entry_valid;

  // a lease with one tick or less left goes away on a tick
  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      tick_valid_next[k] = entry_valid[k] && (entry_ticks_left[k] > TicksW'(1));
    end
  end

  // wanted address lies in the 256 offsets above the base (mod 2^32)
  assign diff_in_pool = (diff[AddrW-1:OffsetW] == '0);
  assign scan_last    = (probe_off == (pool_size - OffsetW'(1)));

  // sequencer, control state and reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      entry_valid <= '0;
      pool_base   <= POOL_BASE_RESET;
      pool_size   <= POOL_SIZE_RESET;
      hold_ticks  <= HOLD_TICKS_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POOL_BASE:  pool_base  <= cfg_data;
          REG_POOL_SIZE:  pool_size  <= cfg_data[OffsetW-1:0];
          REG_HOLD_TICKS: hold_ticks <= cfg_data[TicksW-1:0];
          default: ;
        endcase
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (tick_take) begin
            entry_valid <= tick_valid_next;
          end else if (req_take) begin
            diff  <= req_item.wanted_address - pool_base;
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (diff_in_pool && held) begin
            res_kind <= REPLY_NAK_LEASED;
            res_addr <= '0;
            state    <= S_DONE;
          end else if (!free_any || (pool_size == '0)) begin
            res_kind <= REPLY_NAK_FULL;
            res_addr <= '0;
            state    <= S_DONE;
          end else begin
            slot      <= free_slot;
            probe_off <= '0;
            state     <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (!held) begin
            entry_valid[slot] <= 1'b1;
            res_kind          <= REPLY_ACK;
            res_addr          <= pool_base + AddrW'(probe_off);
            state             <= S_DONE;
          end else if (scan_last) begin
            res_kind <= REPLY_NAK_FULL;
            res_addr <= '0;
            state    <= S_DONE;
          end else begin
            probe_off <= probe_off + OffsetW'(1);
          end
        end

        S_DONE: begin
          // hand over once the output register is free or draining
          if (rsp_load) begin
            rsp_item.reply_kind      <= res_kind;
            rsp_item.granted_address <= res_addr;
            state                    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // lease offsets and counters: written on a grant, counted down on a tick
  always_ff @(posedge clk) begin
    if (tick_take) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (tick_valid_next[k]) begin
          entry_ticks_left[k] <= entry_ticks_left[k] - TicksW'(1);
        end
      end
    end else if ((state == S_SCAN) && !held) begin
      entry_offset[slot]     <= probe_off;
      entry_ticks_left[slot] <= hold_ticks;
    end
  end

endmodule

>>> rtl/core/apla_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apla_checker
// port-level checks on the address pool lease allocator
// ---------------------------------------------------------------------------
module apla_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_stall,
  input apla_pkg::req_item_t            req_item,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input apla_pkg::rsp_item_t            rsp_item
);
  import apla_pkg::*;

  // a stalled reply holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled reply changed");

  // only an ACK carries an address
  a_nak_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_item.reply_kind != REPLY_ACK) |-> rsp_item.granted_address == '0)
    else $error("NAK with non-zero address");

  // a request keeps the block busy for the following cycle
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req_item.action == ACTION_REQUEST) |=> req_stall)
    else $error("request transfer not followed by busy");

  // a new reply is only loaded while a request is being served
  a_rsp_from_req: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("reply appeared with no request in progress");

endmodule

bind address_pool_lease_allocator apla_checker u_apla_checker (.*);
